// File: hdl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, register indexes, status codes and the CRC-16/MODBUS byte
// update for the CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] REG_FOOTER_FIRST  = 3'd2;
    localparam logic [2:0] REG_FOOTER_SECOND = 3'd3;
    localparam logic [2:0] REG_MAX_LEN       = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // End-of-frame status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_FOOTER = 2'd2;
    localparam logic [1:0] ST_LENGTH = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Depth of the result queue between parser and output
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       is_last_payload;
        logic [1:0] frame_status;
    } result_t;

    // One byte of reflected CRC-16/MODBUS
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hdl/crcfr_if.sv
// ----------------------------------------------------------------------------
// crcfr_if
// Valid/ready channels of the frame receiver: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface crcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface crcfr_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       is_last_payload;
    logic [1:0] frame_status;

    modport source (output valid, output kind, output data_byte,
                    output is_last_payload, output frame_status, input ready);
    modport sink   (input valid, input kind, input data_byte,
                    input is_last_payload, input frame_status, output ready);
endinterface

interface crcfr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [crcfr_pkg::CFG_IDX_W-1:0]  index;
    logic [crcfr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Deframer for header / length / payload / CRC-16 MODBUS / footer frames.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while its result queue has
// room: the parser walks the frame and folds each header, length and
// payload byte into the CRC with a byte-wide update in the same cycle.
// A result (payload byte, or end-of-frame status) appears on the output in
// the cycle after the byte that causes it is taken, and waits in a two-entry
// queue; input is held off only while that queue is full. There is no
// clearing pass after reset, and configuration writes are never held off.
module crc16_frame_receiver #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    crcfr_byte_if.sink    byte_ch,
    crcfr_res_if.source   res_ch,
    crcfr_cfg_if.sink     cfg
);

    logic               q_full;
    logic               step;
    logic               push;
    crcfr_pkg::result_t result;

    // Accept a byte whenever the queue has room for its result
    assign byte_ch.ready = !q_full;
    assign step          = byte_ch.valid && !q_full;

    crcfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (byte_ch.in_byte),
        .cfg     (cfg),
        .push    (push),
        .result  (result)
    );

    crcfr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .result (result),
        .full   (q_full),
        .res_ch (res_ch)
    );

endmodule

// File: hdl/crcfr_parser.sv
// ----------------------------------------------------------------------------
// crcfr_parser
// Front part: holds the configuration registers, walks the frame format one
// byte per accepted transfer, runs the CRC and produces the result items.
// ----------------------------------------------------------------------------
module crcfr_parser #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    crcfr_cfg_if.sink           cfg,
    output logic                push,
    output crcfr_pkg::result_t  result
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [31:0] MAX_LIM = 32'(MAX_PAYLOAD);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;
    localparam logic [2:0] PH_FOOT1   = 3'd5;
    localparam logic [2:0] PH_FOOT2   = 3'd6;

    logic [7:0]       hf_reg, hf_next;
    logic [7:0]       hs_reg, hs_next;
    logic [7:0]       ff_reg, ff_next;
    logic [7:0]       fs_reg, fs_next;
    logic [10:0]      maxlen_reg, maxlen_next;
    logic [15:0]      seed_reg, seed_next;

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       idx_reg, idx_next;
    logic [23:0]      len_reg, len_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       rcv_lo_reg, rcv_lo_next;
    logic [1:0]       pend_reg, pend_next;

    logic [31:0]      full_len;
    logic             cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    // Apply configuration writes; keep the header seed CRC in step with them
    always_comb
    begin
        hf_next     = hf_reg;
        hs_next     = hs_reg;
        ff_next     = ff_reg;
        fs_next     = fs_reg;
        maxlen_next = maxlen_reg;
        if (cfg_wr)
        begin
            case (cfg.index)
                crcfr_pkg::REG_HEADER_FIRST:  hf_next = cfg.data[7:0];
                crcfr_pkg::REG_HEADER_SECOND: hs_next = cfg.data[7:0];
                crcfr_pkg::REG_FOOTER_FIRST:  ff_next = cfg.data[7:0];
                crcfr_pkg::REG_FOOTER_SECOND: fs_next = cfg.data[7:0];
                crcfr_pkg::REG_MAX_LEN:       maxlen_next = cfg.data;
                default: ;
            endcase
        end
        seed_next = crcfr_pkg::crc_add(crcfr_pkg::CRC_INIT, hf_next);
    end

    assign full_len = {in_byte, len_reg};

    // Advance the frame state on each accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        crc_next    = crc_reg;
        rcv_lo_next = rcv_lo_reg;
        pend_next   = pend_reg;
        push        = 1'b0;
        result      = '0;
        if (step)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (in_byte == hf_reg)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (in_byte == hs_reg)
                    begin
                        crc_next   = crcfr_pkg::crc_add(seed_reg, in_byte);
                        len_next   = '0;
                        idx_next   = 2'd0;
                        phase_next = PH_LENGTH;
                    end
                    else if (in_byte != hf_reg)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LENGTH:
                begin
                    crc_next = crcfr_pkg::crc_add(crc_reg, in_byte);
                    if (idx_reg != 2'd3)
                    begin
                        case (idx_reg)
                            2'd0:    len_next[7:0]   = in_byte;
                            2'd1:    len_next[15:8]  = in_byte;
                            default: len_next[23:16] = in_byte;
                        endcase
                        idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        idx_next = 2'd0;
                        if ((full_len > {21'd0, maxlen_reg}) || (full_len > MAX_LIM))
                        begin
                            push                = 1'b1;
                            result.kind         = crcfr_pkg::KIND_STATUS;
                            result.frame_status = crcfr_pkg::ST_LENGTH;
                            phase_next          = PH_HUNT1;
                        end
                        else
                        begin
                            left_next   = full_len[LEN_W-1:0];
                            rcv_lo_next = 8'd0;
                            phase_next  = (full_len == 32'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next         = crcfr_pkg::crc_add(crc_reg, in_byte);
                    push             = 1'b1;
                    result.kind      = crcfr_pkg::KIND_PAYLOAD;
                    result.data_byte = in_byte;
                    if (left_reg <= LEN_W'(1))
                    begin
                        result.is_last_payload = 1'b1;
                        left_next   = '0;
                        rcv_lo_next = 8'd0;
                        idx_next    = 2'd0;
                        phase_next  = PH_CRC;
                    end
                    else
                    begin
                        left_next = left_reg - LEN_W'(1);
                    end
                end
                PH_CRC:
                begin
                    if (idx_reg == 2'd0)
                    begin
                        rcv_lo_next = in_byte;
                        idx_next    = 2'd1;
                    end
                    else
                    begin
                        idx_next   = 2'd0;
                        pend_next  = ({in_byte, rcv_lo_reg} == crc_reg) ?
                                     crcfr_pkg::ST_OK : crcfr_pkg::ST_CRC;
                        phase_next = PH_FOOT1;
                    end
                end
                PH_FOOT1:
                begin
                    if (in_byte != ff_reg)
                        pend_next = crcfr_pkg::ST_FOOTER;
                    phase_next = PH_FOOT2;
                end
                PH_FOOT2:
                begin
                    push                = 1'b1;
                    result.kind         = crcfr_pkg::KIND_STATUS;
                    result.frame_status = (in_byte != fs_reg) ? crcfr_pkg::ST_FOOTER : pend_reg;
                    pend_next           = crcfr_pkg::ST_OK;
                    phase_next          = PH_HUNT1;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    // Hold configuration and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg     <= 8'hAA;
            hs_reg     <= 8'h55;
            ff_reg     <= 8'h55;
            fs_reg     <= 8'hAA;
            maxlen_reg <= 11'd1024;
            seed_reg   <= crcfr_pkg::crc_add(crcfr_pkg::CRC_INIT, 8'hAA);
            phase_reg  <= PH_HUNT1;
            idx_reg    <= 2'd0;
            len_reg    <= '0;
            left_reg   <= '0;
            crc_reg    <= crcfr_pkg::CRC_INIT;
            rcv_lo_reg <= 8'd0;
            pend_reg   <= crcfr_pkg::ST_OK;
        end
        else
        begin
            hf_reg     <= hf_next;
            hs_reg     <= hs_next;
            ff_reg     <= ff_next;
            fs_reg     <= fs_next;
            maxlen_reg <= maxlen_next;
            seed_reg   <= seed_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            crc_reg    <= crc_next;
            rcv_lo_reg <= rcv_lo_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// File: hdl/crcfr_queue.sv
// ----------------------------------------------------------------------------
// crcfr_queue
// Back part: a short result queue that decouples the parser from the
// downstream sink and drives the result channel.
// ----------------------------------------------------------------------------
module crcfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  crcfr_pkg::result_t result,
    output logic               full,
    crcfr_res_if.source        res_ch
);

    localparam int DEPTH = crcfr_pkg::QDEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    crcfr_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign full = (cnt_reg == CNT_W'(DEPTH));
    assign pop  = res_ch.valid && res_ch.ready;

    // Drive the head entry
    assign res_ch.valid           = (cnt_reg != '0);
    assign res_ch.kind            = mem[rd_reg].kind;
    assign res_ch.data_byte       = mem[rd_reg].data_byte;
    assign res_ch.is_last_payload = mem[rd_reg].is_last_payload;
    assign res_ch.frame_status    = mem[rd_reg].frame_status;

    // Advance pointers and count
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: dv/tb_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Self-checking bench for the CRC-16 frame receiver. A byte driver feeds
// framed traffic, broken frames and line noise under several register
// settings; a deframer built into the bench predicts every payload byte and
// frame status, and a monitor checks each output transfer in order.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_PAYLOAD   = 1024;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          LONG_HOLD     = 400;
    localparam int          MAX_REPORTS   = 10;
    localparam int unsigned FULL_FRAME    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        GET_LENGTH,
        GET_PAYLOAD,
        GET_CRC,
        GET_FOOT1,
        GET_FOOT2
    } parse_phase_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side drivers of the block's inputs, known from time zero
    logic                             src_valid  = 1'b0;
    logic [7:0]                       src_byte   = '0;
    logic                             sink_ready = 1'b0;
    logic                             cfg_valid  = 1'b0;
    logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    crcfr_byte_if byte_ch();
    crcfr_res_if  res_ch();
    crcfr_cfg_if  cfg_ch();

    assign byte_ch.valid   = src_valid;
    assign byte_ch.in_byte = src_byte;
    assign res_ch.ready    = sink_ready;
    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.index    = cfg_index;
    assign cfg_ch.data     = cfg_data;

    crc16_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .res_ch  (res_ch),
        .cfg     (cfg_ch)
    );

    // Register copies seen by the deframer and the frame builder
    logic [7:0]  hdr_first  = 8'hAA;
    logic [7:0]  hdr_second = 8'h55;
    logic [7:0]  ftr_first  = 8'h55;
    logic [7:0]  ftr_second = 8'hAA;
    logic [10:0] max_len    = 11'd1024;

    // Deframer state
    parse_phase_t parse_phase = SEEK_FIRST;
    logic [1:0]   len_idx     = '0;
    logic [31:0]  frame_len   = '0;
    logic [10:0]  remaining   = '0;
    logic [15:0]  crc_acc     = crcfr_pkg::CRC_INIT;
    logic [15:0]  crc_rx      = '0;
    logic [1:0]   held_status = crcfr_pkg::ST_OK;

    crcfr_pkg::result_t due_results[$];
    logic [7:0]         tx_bytes[$];

    int unsigned queued_items = 0;
    int unsigned bytes_taken  = 0;
    int unsigned payload_out  = 0;
    int unsigned status_tally[4] = '{0, 0, 0, 0};
    int unsigned error_count  = 0;

    int unsigned source_gap_max = 0;
    int unsigned sink_gap_max   = 0;
    int unsigned src_gap        = 0;
    int unsigned sink_wait      = 0;
    int unsigned sink_draw      = 0;
    int unsigned hold_left      = 0;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reflected CRC-16/MODBUS, one byte at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ({1'b0, r[15:1]} ^ crcfr_pkg::CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    function automatic int unsigned length_limit();
        return (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len;
    endfunction

    // Append one byte to the send queue
    function automatic void queue_byte(input logic [7:0] b);
        tx_bytes = {tx_bytes, b};
        queued_items++;
    endfunction

    function automatic void note_due(input logic kind, input logic [7:0] data,
                                     input logic last, input logic [1:0] status);
        crcfr_pkg::result_t r;
        r.kind            = kind;
        r.data_byte       = data;
        r.is_last_payload = last;
        r.frame_status    = status;
        due_results = {due_results, r};
    endfunction

    // Advance the deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        case (parse_phase)
            SEEK_FIRST:
                if (b == hdr_first)
                    parse_phase = SEEK_SECOND;
            SEEK_SECOND:
                if (b == hdr_second)
                begin
                    crc_acc     = crc16_step(crc16_step(crcfr_pkg::CRC_INIT, hdr_first), b);
                    frame_len   = '0;
                    len_idx     = '0;
                    parse_phase = GET_LENGTH;
                end
                else if (b != hdr_first)
                    parse_phase = SEEK_FIRST;
            GET_LENGTH:
            begin
                crc_acc = crc16_step(crc_acc, b);
                frame_len[8*len_idx +: 8] = b;
                if (len_idx != 2'd3)
                    len_idx = len_idx + 2'd1;
                else
                begin
                    len_idx = '0;
                    if (frame_len > length_limit())
                    begin
                        parse_phase = SEEK_FIRST;
                        note_due(crcfr_pkg::KIND_STATUS, 8'h00, 1'b0, crcfr_pkg::ST_LENGTH);
                    end
                    else
                    begin
                        remaining   = frame_len[10:0];
                        crc_rx      = '0;
                        parse_phase = (frame_len == 0) ? GET_CRC : GET_PAYLOAD;
                    end
                end
            end
            GET_PAYLOAD:
            begin
                crc_acc = crc16_step(crc_acc, b);
                if (remaining <= 1)
                begin
                    remaining   = '0;
                    crc_rx      = '0;
                    len_idx     = '0;
                    parse_phase = GET_CRC;
                    note_due(crcfr_pkg::KIND_PAYLOAD, b, 1'b1, crcfr_pkg::ST_OK);
                end
                else
                begin
                    remaining = remaining - 11'd1;
                    note_due(crcfr_pkg::KIND_PAYLOAD, b, 1'b0, crcfr_pkg::ST_OK);
                end
            end
            GET_CRC:
                if (len_idx == 2'd0)
                begin
                    crc_rx  = {8'h00, b};
                    len_idx = 2'd1;
                end
                else
                begin
                    crc_rx[15:8] = b;
                    len_idx      = '0;
                    held_status  = (crc_rx == crc_acc) ? crcfr_pkg::ST_OK : crcfr_pkg::ST_CRC;
                    parse_phase  = GET_FOOT1;
                end
            GET_FOOT1:
            begin
                if (b != ftr_first)
                    held_status = crcfr_pkg::ST_FOOTER;
                parse_phase = GET_FOOT2;
            end
            GET_FOOT2:
            begin
                if (b != ftr_second)
                    held_status = crcfr_pkg::ST_FOOTER;
                note_due(crcfr_pkg::KIND_STATUS, 8'h00, 1'b0, held_status);
                held_status = crcfr_pkg::ST_OK;
                parse_phase = SEEK_FIRST;
            end
            default:
                parse_phase = SEEK_FIRST;
        endcase
    endtask

    // Compare one output transfer with the oldest expectation
    task automatic check_result();
        crcfr_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: unexpected result: kind=%0d data=%02h last=%0d status=%0d",
                         $time, res_ch.kind, res_ch.data_byte, res_ch.is_last_payload,
                         res_ch.frame_status);
            return;
        end
        want = due_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.data_byte !== want.data_byte ||
            res_ch.is_last_payload !== want.is_last_payload ||
            res_ch.frame_status !== want.frame_status)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("%0t: mismatch: got kind=%0d data=%02h last=%0d status=%0d",
                         $time, res_ch.kind, res_ch.data_byte, res_ch.is_last_payload,
                         res_ch.frame_status);
                $display("    expected kind=%0d data=%02h last=%0d status=%0d",
                         want.kind, want.data_byte, want.is_last_payload,
                         want.frame_status);
            end
        end
        if (want.kind == crcfr_pkg::KIND_STATUS)
            status_tally[want.frame_status]++;
        else
            payload_out++;
    endtask

    // Predict on every input transfer, check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && src_valid && byte_ch.ready)
        begin
            deframe_byte(src_byte);
            bytes_taken++;
        end
        if (rst_n && res_ch.valid && sink_ready)
            check_result();
    end

    // Byte driver: hold the offered byte until taken, then idle a drawn gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_gap   <= 0;
        end
        else if (!src_valid || byte_ch.ready)
        begin
            if (src_gap != 0)
            begin
                src_gap   <= src_gap - 1;
                src_valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                src_byte  <= tx_bytes.pop_front();
                src_valid <= 1'b1;
                src_gap   <= $urandom_range(0, source_gap_max);
            end
            else
                src_valid <= 1'b0;
        end
    end

    // Result sink: drawn stall after each transfer, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else if (long_holds_done != long_holds_asked)
        begin
            long_holds_done <= long_holds_done + 1;
            hold_left       <= LONG_HOLD;
            sink_ready      <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            sink_ready <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait  <= sink_wait - 1;
            sink_ready <= (sink_wait == 1);
        end
        else if (res_ch.valid && sink_ready)
        begin
            sink_draw   = $urandom_range(0, sink_gap_max);
            sink_wait  <= sink_draw;
            sink_ready <= (sink_draw == 0);
        end
        else
            sink_ready <= 1'b1;
    end

    // Write one register while the block is idle and mirror it on transfer
    task automatic write_reg(input logic [crcfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [crcfr_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            crcfr_pkg::REG_HEADER_FIRST:  hdr_first  = value[7:0];
            crcfr_pkg::REG_HEADER_SECOND: hdr_second = value[7:0];
            crcfr_pkg::REG_FOOTER_FIRST:  ftr_first  = value[7:0];
            crcfr_pkg::REG_FOOTER_SECOND: ftr_second = value[7:0];
            crcfr_pkg::REG_MAX_LEN:       max_len    = value;
            default: ;
        endcase
    endtask

    // Drain: wait until everything is sent and every result is back, then let the block sit quiet
    task automatic settle();
        while (tx_bytes.size() != 0 || src_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Queue a frame under the current registers; keep cuts it short
    task automatic push_frame(input logic [31:0] len, input bit crc_bad,
                              input logic [1:0] foot_bad, input int unsigned keep);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        crc = crcfr_pkg::CRC_INIT;
        frame = {hdr_first, hdr_second, len[7:0], len[15:8], len[23:16], len[31:24]};
        if (len <= length_limit())
        begin
            for (int k = 0; k < len; k++)
                frame = {frame, 8'($urandom)};
            foreach (frame[k])
                crc = crc16_step(crc, frame[k]);
            if (crc_bad)
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            frame = {frame, crc[7:0], crc[15:8]};
            frame = {frame, ftr_first ^ (foot_bad[0] ? 8'($urandom_range(1, 255)) : 8'h00)};
            frame = {frame, ftr_second ^ (foot_bad[1] ? 8'($urandom_range(1, 255)) : 8'h00)};
        end
        for (int k = 0; k < frame.size() && k < keep; k++)
            queue_byte(frame[k]);
    endtask

    // Well-formed frames with random content, mixed with broken ones and noise
    task automatic random_traffic(input int unsigned quota);
        int unsigned goal;
        int unsigned lim;
        int unsigned pick;
        int unsigned len;
        int unsigned errs;
        goal = queued_items + quota;
        while (queued_items < goal)
        begin
            lim  = length_limit();
            pick = $urandom_range(0, 99);
            errs = $urandom_range(0, 9);
            if (pick < 60)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 96) : $urandom_range(0, 12);
                if (len > lim)
                    len = lim;
                push_frame(len, errs == 0 || errs == 2,
                           (errs == 1 || errs == 2) ? 2'($urandom_range(1, 3)) : 2'b00,
                           FULL_FRAME);
            end
            else if (pick < 66 && lim <= 128)
                push_frame(lim + $urandom_range(0, 1), errs == 0, 2'b00, FULL_FRAME);
            else if (pick < 76)
                push_frame($urandom | (32'd1 << $urandom_range(11, 31)), 1'b0, 2'b00, FULL_FRAME);
            else if (pick < 88)
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom));
            else
                push_frame($urandom_range(0, 6), 1'b0, 2'b00, $urandom_range(1, 12));
        end
    endtask

    initial
    begin
        logic [7:0]  split_frame[$];
        logic [15:0] split_crc;
        logic [7:0]  new_footer;
        logic [7:0]  same_hdr;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: repeated header byte, crc error, both checks bad, oversize
        source_gap_max = 8;
        sink_gap_max   = 8;
        queue_byte(hdr_first);
        push_frame(0, 1'b1, 2'b00, FULL_FRAME);
        push_frame(1, 1'b1, 2'b10, FULL_FRAME);
        push_frame(32'hFFFF_FFFF, 1'b0, 2'b00, FULL_FRAME);
        random_traffic(90);
        settle();

        // Extreme marker bytes, zero length limit, writes to unused indexes
        write_reg(crcfr_pkg::REG_HEADER_FIRST, 11'h700);
        write_reg(crcfr_pkg::REG_HEADER_SECOND, 11'h0FF);
        write_reg(crcfr_pkg::REG_FOOTER_FIRST, 11'h4FF);
        write_reg(crcfr_pkg::REG_FOOTER_SECOND, 11'h300);
        write_reg(crcfr_pkg::REG_MAX_LEN, 11'd0);
        for (int i = crcfr_pkg::REG_MAX_LEN + 1; i < 8; i++)
            write_reg(crcfr_pkg::CFG_IDX_W'(i), crcfr_pkg::CFG_DATA_W'($urandom));
        source_gap_max = 0;
        sink_gap_max   = 0;
        random_traffic(80);
        settle();

        // Register limit above the build limit: largest frame and one past it
        write_reg(crcfr_pkg::REG_MAX_LEN, 11'h7FF);
        write_reg(crcfr_pkg::REG_HEADER_FIRST, crcfr_pkg::CFG_DATA_W'($urandom));
        write_reg(crcfr_pkg::REG_HEADER_SECOND, crcfr_pkg::CFG_DATA_W'($urandom));
        write_reg(crcfr_pkg::REG_FOOTER_FIRST, crcfr_pkg::CFG_DATA_W'($urandom));
        write_reg(crcfr_pkg::REG_FOOTER_SECOND, crcfr_pkg::CFG_DATA_W'($urandom));
        source_gap_max = 2;
        sink_gap_max   = 2;
        push_frame(MAX_PAYLOAD, 1'b0, 2'b00, FULL_FRAME);
        push_frame(MAX_PAYLOAD + 1, 1'b0, 2'b00, FULL_FRAME);
        random_traffic(50);
        settle();

        // Equal header bytes, small limit; hold off the sink while bytes keep coming
        same_hdr = 8'($urandom);
        write_reg(crcfr_pkg::REG_HEADER_FIRST, {3'b000, same_hdr});
        write_reg(crcfr_pkg::REG_HEADER_SECOND, {3'b000, same_hdr});
        write_reg(crcfr_pkg::REG_FOOTER_FIRST, crcfr_pkg::CFG_DATA_W'($urandom));
        write_reg(crcfr_pkg::REG_FOOTER_SECOND, crcfr_pkg::CFG_DATA_W'($urandom));
        write_reg(crcfr_pkg::REG_MAX_LEN, crcfr_pkg::CFG_DATA_W'($urandom_range(1, 64)));
        source_gap_max = 0;
        sink_gap_max   = 8;
        random_traffic(100);
        long_holds_asked++;
        settle();

        // Footer change in the middle of a frame takes effect for that frame
        write_reg(crcfr_pkg::REG_HEADER_FIRST, 11'h0AA);
        write_reg(crcfr_pkg::REG_HEADER_SECOND, 11'h055);
        write_reg(crcfr_pkg::REG_MAX_LEN, 11'd1023);
        source_gap_max = 8;
        sink_gap_max   = 8;
        split_frame = {hdr_first, hdr_second, 8'd3, 8'd0, 8'd0, 8'd0,
                       8'($urandom), 8'($urandom), 8'($urandom)};
        split_crc = crcfr_pkg::CRC_INIT;
        foreach (split_frame[k])
            split_crc = crc16_step(split_crc, split_frame[k]);
        for (int k = 0; k < 8; k++)
            queue_byte(split_frame[k]);
        settle();
        new_footer = ~ftr_first;
        write_reg(crcfr_pkg::REG_FOOTER_FIRST, {3'b000, new_footer});
        queue_byte(split_frame[8]);
        queue_byte(split_crc[7:0]);
        queue_byte(split_crc[15:8]);
        queue_byte(new_footer);
        queue_byte(ftr_second);
        random_traffic(70);
        settle();

        $display("Covered %0d bytes in and %0d payload bytes out over five register setups",
                 bytes_taken, payload_out);
        $display("Frame status ok/crc/footer/length: %0d/%0d/%0d/%0d",
                 status_tally[crcfr_pkg::ST_OK], status_tally[crcfr_pkg::ST_CRC],
                 status_tally[crcfr_pkg::ST_FOOTER], status_tally[crcfr_pkg::ST_LENGTH]);
        if (error_count == 0)
            $display("[crc16_frame_receiver] OK");
        else
            $display("[crc16_frame_receiver] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[crc16_frame_receiver] ERROR");
        $finish;
    end

endmodule
